FILE: src/tap_tempo_estimator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tap tempo estimator checker.
// ----------------------------------------------------------------------------
`ifndef TAP_TEMPO_ESTIMATOR_MACROS_SVH
`define TAP_TEMPO_ESTIMATOR_MACROS_SVH

// Checks a property only while the block is out of reset.
`define TTE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property at every clock edge, reset included.
`define TTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg
// Widths, state encoding and divider interface types of the tap tempo
// estimator.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int TRIG_W    = 32;
  localparam int PERIOD_W  = 32;
  localparam int TICK_W    = 64;
  localparam int DIGIT_W   = 4;
  localparam int DIGITS    = TICK_W / DIGIT_W;
  localparam int DIG_IDX_W = $clog2(DIGITS);

  localparam int AVG_DEPTH = 4;
  localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W     = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W     = PERIOD_W + SLOT_W;
  localparam int DIVC_W    = $clog2(SUM_W);

  localparam logic [PERIOD_W-1:0] MAX_INTERVAL_RESET = 32'd48000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_DECIDE,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/tap_tempo_estimator.sv
// ----------------------------------------------------------------------------
// Tap tempo estimator: moving average of tap intervals.
// A tick without a tap gives its item in the cycle after it is accepted.
// A tap runs a digit-serial interval subtract and compare, a decision step,
// a sum over the stored intervals, a serial division and an output step;
// a rejected interval skips the sum and division and goes to the output step.
// Synchronous active-low reset clears the control state; no clearing pass.
// ----------------------------------------------------------------------------
module tap_tempo_estimator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tte_pkg::TRIG_W-1:0]   in_trigger_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [tte_pkg::PERIOD_W-1:0] out_period_ticks,
  output logic                                out_tap_seen,
  input  logic                                cfg_wr_en,
  input  logic        [tte_pkg::PERIOD_W-1:0] cfg_wr_data
);

  tte_pkg::state_t state_r, state_nxt;

  logic                         was_high_r, was_high_nxt;
  logic [tte_pkg::TICK_W-1:0]   tick_r, tick_nxt;
  logic [tte_pkg::TICK_W-1:0]   last_r, last_nxt;
  logic [tte_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic [tte_pkg::CNT_W-1:0]    filled_r, filled_nxt;
  logic [tte_pkg::PERIOD_W-1:0] held_r, held_nxt;
  logic [tte_pkg::PERIOD_W-1:0] max_r;

  logic [tte_pkg::TICK_W-1:0]    a_sh_r, a_sh_nxt;
  logic [tte_pkg::TICK_W-1:0]    b_sh_r, b_sh_nxt;
  logic [tte_pkg::TICK_W-1:0]    m_sh_r, m_sh_nxt;
  logic [tte_pkg::TICK_W-1:0]    delta_sh_r, delta_sh_nxt;
  logic                          bw1_r, bw1_nxt;
  logic                          bw2_r, bw2_nxt;
  logic [tte_pkg::DIG_IDX_W-1:0] dig_r, dig_nxt;
  logic [tte_pkg::SUM_W-1:0]     acc_r, acc_nxt;
  logic [tte_pkg::CNT_W-1:0]     sum_idx_r, sum_idx_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [tte_pkg::PERIOD_W-1:0] out_period_r, out_period_nxt;
  logic                         out_tap_r, out_tap_nxt;

  logic [tte_pkg::PERIOD_W-1:0] ring [tte_pkg::AVG_DEPTH];
  logic                         ring_we;

  logic                         in_accept;
  logic                         high;
  logic                         tap;
  logic [tte_pkg::DIGIT_W:0]    d_full;
  logic [tte_pkg::DIGIT_W:0]    c_full;
  logic [tte_pkg::CNT_W-1:0]    slot_inc;
  logic [tte_pkg::SUM_W-1:0]    acc_sum;

  tte_pkg::div_req_t div_req;
  tte_pkg::div_rsp_t div_rsp;

  tte_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall  = (state_r != tte_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign high      = (in_trigger_level > 0);
  assign tap       = high && !was_high_r;

  assign d_full   = {1'b0, a_sh_r[tte_pkg::DIGIT_W-1:0]}
                  - {1'b0, b_sh_r[tte_pkg::DIGIT_W-1:0]}
                  - {{tte_pkg::DIGIT_W{1'b0}}, bw1_r};
  assign c_full   = {1'b0, m_sh_r[tte_pkg::DIGIT_W-1:0]}
                  - {1'b0, d_full[tte_pkg::DIGIT_W-1:0]}
                  - {{tte_pkg::DIGIT_W{1'b0}}, bw2_r};
  assign slot_inc = tte_pkg::CNT_W'(slot_r) + tte_pkg::CNT_W'(1);
  assign acc_sum  = acc_r + tte_pkg::SUM_W'(ring[sum_idx_r[tte_pkg::SLOT_W-1:0]]);

  always_comb begin
    state_nxt      = state_r;
    was_high_nxt   = was_high_r;
    tick_nxt       = tick_r;
    last_nxt       = last_r;
    slot_nxt       = slot_r;
    filled_nxt     = filled_r;
    held_nxt       = held_r;
    a_sh_nxt       = a_sh_r;
    b_sh_nxt       = b_sh_r;
    m_sh_nxt       = m_sh_r;
    delta_sh_nxt   = delta_sh_r;
    bw1_nxt        = bw1_r;
    bw2_nxt        = bw2_r;
    dig_nxt        = dig_r;
    acc_nxt        = acc_r;
    sum_idx_nxt    = sum_idx_r;
    out_period_nxt = out_period_r;
    out_tap_nxt    = out_tap_r;
    out_valid_nxt  = out_stall ? out_valid_r : 1'b0;
    ring_we        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = acc_sum;
    div_req.divisor  = filled_r;

    unique case (state_r)
      tte_pkg::ST_IDLE: begin
        if (in_accept) begin
          was_high_nxt = high;
          tick_nxt     = tick_r + tte_pkg::TICK_W'(1);
          if (tap) begin
            last_nxt  = tick_r;
            a_sh_nxt  = tick_r;
            b_sh_nxt  = last_r;
            m_sh_nxt  = tte_pkg::TICK_W'(max_r);
            bw1_nxt   = 1'b0;
            bw2_nxt   = 1'b0;
            dig_nxt   = '0;
            state_nxt = tte_pkg::ST_DELTA;
          end else begin
            out_valid_nxt  = 1'b1;
            out_period_nxt = held_r;
            out_tap_nxt    = 1'b0;
          end
        end
      end
      tte_pkg::ST_DELTA: begin
        a_sh_nxt     = a_sh_r >> tte_pkg::DIGIT_W;
        b_sh_nxt     = b_sh_r >> tte_pkg::DIGIT_W;
        m_sh_nxt     = m_sh_r >> tte_pkg::DIGIT_W;
        delta_sh_nxt = {d_full[tte_pkg::DIGIT_W-1:0],
                        delta_sh_r[tte_pkg::TICK_W-1:tte_pkg::DIGIT_W]};
        bw1_nxt      = d_full[tte_pkg::DIGIT_W];
        bw2_nxt      = c_full[tte_pkg::DIGIT_W];
        dig_nxt      = dig_r + tte_pkg::DIG_IDX_W'(1);
        if (dig_r == tte_pkg::DIG_IDX_W'(tte_pkg::DIGITS - 1)) begin
          state_nxt = tte_pkg::ST_DECIDE;
        end
      end
      tte_pkg::ST_DECIDE: begin
        if (bw2_r) begin
          slot_nxt   = '0;
          filled_nxt = '0;
          state_nxt  = tte_pkg::ST_EMIT;
        end else begin
          ring_we     = 1'b1;
          filled_nxt  = (slot_inc > filled_r) ? slot_inc : filled_r;
          slot_nxt    = (slot_inc >= tte_pkg::CNT_W'(tte_pkg::AVG_DEPTH)) ?
                        '0 : slot_inc[tte_pkg::SLOT_W-1:0];
          acc_nxt     = '0;
          sum_idx_nxt = '0;
          state_nxt   = tte_pkg::ST_SUM;
        end
      end
      tte_pkg::ST_SUM: begin
        acc_nxt     = acc_sum;
        sum_idx_nxt = sum_idx_r + tte_pkg::CNT_W'(1);
        if (sum_idx_r == filled_r - tte_pkg::CNT_W'(1)) begin
          div_req.start = 1'b1;
          state_nxt     = tte_pkg::ST_DIV;
        end
      end
      tte_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          held_nxt  = div_rsp.quotient;
          state_nxt = tte_pkg::ST_EMIT;
        end
      end
      tte_pkg::ST_EMIT: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt  = 1'b1;
          out_period_nxt = held_r;
          out_tap_nxt    = 1'b1;
          state_nxt      = tte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tte_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tte_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_high_r  <= 1'b0;
      tick_r      <= '0;
      last_r      <= '0;
      slot_r      <= '0;
      filled_r    <= '0;
      held_r      <= '0;
      max_r       <= tte_pkg::MAX_INTERVAL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      was_high_r  <= was_high_nxt;
      tick_r      <= tick_nxt;
      last_r      <= last_nxt;
      slot_r      <= slot_nxt;
      filled_r    <= filled_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
    a_sh_r       <= a_sh_nxt;
    b_sh_r       <= b_sh_nxt;
    m_sh_r       <= m_sh_nxt;
    delta_sh_r   <= delta_sh_nxt;
    bw1_r        <= bw1_nxt;
    bw2_r        <= bw2_nxt;
    dig_r        <= dig_nxt;
    acc_r        <= acc_nxt;
    sum_idx_r    <= sum_idx_nxt;
    out_period_r <= out_period_nxt;
    out_tap_r    <= out_tap_nxt;
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[slot_r] <= delta_sh_r[tte_pkg::PERIOD_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_period_ticks = out_period_r;
  assign out_tap_seen     = out_tap_r;

endmodule

FILE: src/tte_serial_div.sv
// ----------------------------------------------------------------------------
// tte_serial_div
// Restoring divider that produces one quotient bit per cycle from the sum
// of the stored intervals and the number of stored intervals.
// ----------------------------------------------------------------------------
module tte_serial_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tte_pkg::div_req_t req,
  output tte_pkg::div_rsp_t rsp
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [tte_pkg::DIVC_W-1:0] cnt_r, cnt_nxt;
  logic [tte_pkg::SUM_W-1:0]  num_r, num_nxt;
  logic [tte_pkg::SUM_W-1:0]  quo_r, quo_nxt;
  logic [tte_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [tte_pkg::CNT_W-1:0]  den_r, den_nxt;
  logic [tte_pkg::CNT_W:0]    trial;
  logic [tte_pkg::CNT_W:0]    diff;
  logic                       ge;

  always_comb begin
    trial    = {rem_r, num_r[tte_pkg::SUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = req.dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[tte_pkg::SUM_W-2:0], 1'b0};
      quo_nxt = {quo_r[tte_pkg::SUM_W-2:0], ge};
      rem_nxt = ge ? diff[tte_pkg::CNT_W-1:0] : trial[tte_pkg::CNT_W-1:0];
      cnt_nxt = cnt_r + tte_pkg::DIVC_W'(1);
      if (cnt_r == tte_pkg::DIVC_W'(tte_pkg::SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[tte_pkg::PERIOD_W-1:0];

endmodule

FILE: src/tte_checker.sv
// ----------------------------------------------------------------------------
// tte_checker
// Port-level checks of the tap tempo estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "tap_tempo_estimator_macros.svh"

module tte_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tte_pkg::PERIOD_W-1:0] out_period_ticks,
  input logic                         out_tap_seen
);

  property p_out_hold;
    out_valid && out_stall |=>
      out_valid && $stable(out_period_ticks) && $stable(out_tap_seen);
  endproperty

  property p_reset_empty;
    !rst_n |=> !out_valid;
  endproperty

  property p_no_overrun;
    out_valid && out_stall |-> in_stall;
  endproperty

  property p_accept_progress;
    in_valid && !in_stall |=> out_valid || in_stall;
  endproperty

  // A stalled result item holds its value.
  `TTE_ASSERT(a_out_hold, clk, rst_n, p_out_hold, "stalled result item changed")

  // Reset leaves no result item pending.
  `TTE_ASSERT_ALWAYS(a_reset_empty, clk, p_reset_empty, "result item valid after reset")

  // No new item is taken while a finished result is blocked.
  `TTE_ASSERT(a_no_overrun, clk, rst_n, p_no_overrun, "input taken while result blocked")

  // An accepted item either yields its result at once or keeps the input busy.
  `TTE_ASSERT(a_accept_progress, clk, rst_n, p_accept_progress, "accepted item left no trace")

endmodule

bind tap_tempo_estimator tte_checker u_tte_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the tap tempo estimator
// A scoreboard predicts, for each accepted trigger item, the held period and
// the tap flag, and compares them with the block's results in order. Directed
// items come first, then tap trains and noise under several interval limits,
// with random idling on the input channel and random stalling on the results.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [tte_pkg::PERIOD_W-1:0] period;
    logic                         tap;
  } tempo_result_t;

  class tempo_scoreboard;
    logic [tte_pkg::PERIOD_W-1:0] max_interval;
    bit                           level_was_high;
    logic [tte_pkg::TICK_W-1:0]   tick_num;
    logic [tte_pkg::TICK_W-1:0]   last_tap;
    logic [tte_pkg::PERIOD_W-1:0] intervals[tte_pkg::AVG_DEPTH];
    int unsigned                  slot;
    int unsigned                  filled;
    logic [tte_pkg::PERIOD_W-1:0] held_period;
    tempo_result_t                expected_q[$];
    int unsigned                  errors;
    int unsigned                  taps;
    int unsigned                  rejects;

    function new();
      max_interval   = tte_pkg::MAX_INTERVAL_RESET;
      level_was_high = 1'b0;
      tick_num       = '0;
      last_tap       = '0;
      slot           = 0;
      filled         = 0;
      held_period    = '0;
      errors         = 0;
      taps           = 0;
      rejects        = 0;
    endfunction

    function void set_max_interval(logic [tte_pkg::PERIOD_W-1:0] value);
      max_interval = value;
    endfunction

    function void add_interval(logic [tte_pkg::PERIOD_W-1:0] interval);
      logic [63:0] sum;
      sum = '0;
      intervals[slot] = interval;
      slot++;
      if (slot > filled) begin
        filled = slot;
      end
      if (slot >= tte_pkg::AVG_DEPTH) begin
        slot = 0;
      end
      for (int k = 0; k < filled; k++) begin
        sum += intervals[k];
      end
      held_period = 32'(sum / filled);
    endfunction

    function void note_tick(logic signed [tte_pkg::TRIG_W-1:0] level);
      bit                         high;
      bit                         tap;
      logic [tte_pkg::TICK_W-1:0] delta;
      tempo_result_t              res;
      high = (level > 0);
      tap  = high && !level_was_high;
      if (tap) begin
        taps++;
        delta = tick_num - last_tap;
        if (delta > {32'd0, max_interval}) begin
          rejects++;
          slot   = 0;
          filled = 0;
        end else begin
          add_interval(delta[tte_pkg::PERIOD_W-1:0]);
        end
        last_tap = tick_num;
      end
      level_was_high = high;
      tick_num++;
      res.period = held_period;
      res.tap    = tap;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [tte_pkg::PERIOD_W-1:0] period, logic tap);
      tempo_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item, period_ticks %0d tap_seen %0b", $time, period, tap);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (period !== exp_res.period) begin
        $display("%0t: period_ticks expected %0d, got %0d", $time, exp_res.period, period);
        errors++;
      end
      if (tap !== exp_res.tap) begin
        $display("%0t: tap_seen expected %0b, got %0b", $time, exp_res.tap, tap);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [tte_pkg::TRIG_W-1:0]   in_trigger_level = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic        [tte_pkg::PERIOD_W-1:0] out_period_ticks;
  logic                                out_tap_seen;
  logic                                cfg_wr_en = 1'b0;
  logic        [tte_pkg::PERIOD_W-1:0] cfg_wr_data = '0;

  tempo_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  int unsigned     ticks_sent = 0;
  int unsigned     limit_writes = 0;
  bit              steady = 1'b0;
  bit              hold_request = 1'b0;

  tap_tempo_estimator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_trigger_level (in_trigger_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_period_ticks (out_period_ticks),
    .out_tap_seen     (out_tap_seen),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(30, 120);
  endfunction

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int unsigned stall_len;
    int unsigned run_len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall_len = 500;
      end else begin
        stall_len = pick_gap();
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      run_len = $urandom_range(1, 20);
      repeat (run_len) begin
        @(posedge clk);
        if (out_valid) begin
          sb.check_result(out_period_ticks, out_tap_seen);
        end
      end
    end
  end

  function automatic logic signed [31:0] high_level();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h0000_0001;
      1: v = 32'h7FFF_FFFF;
      default: begin
        v = $urandom & 32'h7FFF_FFFF;
        if (v == 0) begin
          v = 32'h0000_0001;
        end
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] low_level();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'hFFFF_FFFF;
      2, 3, 4, 5: v = 32'h0000_0000;
      default: v = $urandom | 32'h8000_0000;
    endcase
    return v;
  endfunction

  task automatic send_tick(logic signed [31:0] level, int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_trigger_level <= level;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_tick(level);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_max_interval(logic [31:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_max_interval(value);
    limit_writes++;
  endtask

  task automatic run_phase(logic [31:0] max_ivl, int unsigned budget);
    int unsigned count;
    int unsigned upper;
    int unsigned interval;
    int unsigned high_len;
    write_max_interval(max_ivl);
    upper = (max_ivl <= 60) ? max_ivl + max_ivl / 3 + 3 : 40;
    count = 0;
    while (count < budget) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_tick($urandom, pick_gap());
          count++;
        end
      end else begin
        interval = $urandom_range(2, upper);
        high_len = $urandom_range(1, interval - 1);
        for (int i = 0; i < interval; i++) begin
          send_tick((i < high_len) ? high_level() : low_level(), pick_gap());
          count++;
        end
      end
    end
  endtask

  initial begin
    logic signed [31:0] directed[$];
    directed = '{32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h0000_0001, 32'hFFFF_FFFF, 32'h4000_0000, 32'h0000_0000,
                 32'h0000_0000, 32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'h2AAA_AAAA, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001,
                 32'h8000_0001, 32'h1234_5678, 32'h0000_0000, 32'hFFFF_0000,
                 32'h0F0F_0F0F, 32'hF0F0_F0F0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // The first tap lands on tick zero; later ones wrap the interval ring.
    foreach (directed[i]) begin
      send_tick(directed[i], 0);
    end

    // The receiver holds off for a long stretch while items keep coming.
    wait_drained();
    hold_request = 1'b1;
    repeat (40) begin
      send_tick(($urandom_range(0, 1) == 1) ? high_level() : low_level(), 0);
    end

    steady = 1'b1;
    run_phase(32'd0, 80);
    steady = 1'b0;
    run_phase(32'hFFFF_FFFF, 150);
    run_phase(32'd12, 150);
    steady = 1'b1;
    run_phase(tte_pkg::MAX_INTERVAL_RESET, 130);
    steady = 1'b0;
    run_phase(32'd1, 100);
    run_phase(32'd30, 150);
    run_phase($urandom_range(2, 60), 150);
    run_phase($urandom_range(3, 25), 150);

    wait_drained();
    repeat (80) @(posedge clk);

    $display("Sent %0d ticks holding %0d taps, %0d of them beyond the interval limit,",
             ticks_sent, sb.taps, sb.rejects);
    $display("under %0d limit settings from zero up to the full 32-bit range.", limit_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
